// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is held.
`define ADRC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("adrc assertion failed");

// Assertion that is also checked during reset.
`define ADRC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("adrc assertion failed");

`endif

// ===== design/adrc_pkg.sv =====
package adrc_pkg;

  localparam int CHANNELS    = 8;
  localparam int CH_BITS     = 3;
  localparam int CH_IDX      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SAMPLE_BITS = 24;
  localparam int LEVEL_SHIFT = 32 - SAMPLE_BITS;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [19:0] DB_FLOOR_Q8      = -20'sd61440;
  localparam logic [18:0]        DB_PER_OCTAVE    = 19'd394566;
  localparam logic [13:0]        OCTAVE_PER_DB20  = 14'd10885;

  // Register reset values.
  localparam logic signed [15:0] THRESHOLD_RST = -16'sd5120;
  localparam logic [16:0]        RATIO_RST     = 17'd16384;
  localparam logic [13:0]        KNEE_RST      = 14'd0;
  localparam logic signed [14:0] MAKEUP_RST    = 15'sd0;
  localparam logic [15:0]        ATTACK_RST    = 16'd64880;
  localparam logic [15:0]        RELEASE_RST   = 16'd65208;
  localparam logic [15:0]        MSQ_RST       = 16'd65208;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 8'd0,
    REG_RATIO_INV = 8'd1,
    REG_KNEE      = 8'd2,
    REG_MAKEUP    = 8'd3,
    REG_ATTACK    = 8'd4,
    REG_RELEASE   = 8'd5,
    REG_MSQ       = 8'd6,
    REG_RMS_MODE  = 8'd7
  } cfg_reg_t;

  typedef logic [31:0] root_tab_t [16];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30, k = 1 .. 16.
  function automatic root_tab_t make_roots();
    root_tab_t t;
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    t[0] = r[31:0];
    for (int k = 1; k < 16; k++) begin
      r = isqrt64(r << 30);
      t[k] = r[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = make_roots();

endpackage

// ===== design/adrc_mul.sv =====
module adrc_mul (
  input  logic                                clk,
  input  logic signed [adrc_pkg::MUL_W-1:0]   a,
  input  logic signed [adrc_pkg::MUL_W-1:0]   b,
  output logic signed [adrc_pkg::PROD_W-1:0]  p_r
);

  // Registered product; the result of operands set in one cycle is read in the next.
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ===== design/audio_dynamic_range_compressor.sv =====
// Feed-forward compressor with soft or hard knee for up to eight channels of signed
// Q1.23 audio. Each item is a channel number and a sample; each gives exactly one result
// with the gain-scaled, saturated sample for that channel. A channel's peak or RMS
// detector, release hold and attack envelope live in registers cleared by reset. All
// products run through one registered 34 x 34 multiplier under a sequencer; the
// square root, the normalising shift and the knee division are done one bit per cycle,
// and the log takes 16 squaring rounds, one bit per round. An item passes through the
// normalising shift and the 16 log rounds for a nonzero envelope, the gain product of up
// to 16 rounds, plus the root in RMS mode and the division inside a soft knee. The input
// is not ready while an item is in work; a finished result waits in the output register
// and does not hold up the next item until that one is finished as well. Configuration
// writes are always accepted and must be made while the block is idle.
module audio_dynamic_range_compressor (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [adrc_pkg::CH_BITS-1:0]           in_channel,
  input  logic signed [adrc_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [adrc_pkg::CH_BITS-1:0]           out_channel_out,
  output logic signed [adrc_pkg::SAMPLE_BITS-1:0] out_sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [adrc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [adrc_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int SB = adrc_pkg::SAMPLE_BITS;
  localparam int MW = adrc_pkg::MUL_W;
  localparam int PW = adrc_pkg::PROD_W;

  typedef enum logic [28:0] {
    S_IDLE  = 29'd1 << 0,
    S_SQ    = 29'd1 << 1,
    S_MS0   = 29'd1 << 2,
    S_MS1   = 29'd1 << 3,
    S_MS2   = 29'd1 << 4,
    S_MS3   = 29'd1 << 5,
    S_MS4   = 29'd1 << 6,
    S_SQRT  = 29'd1 << 7,
    S_DEC   = 29'd1 << 8,
    S_HOLD  = 29'd1 << 9,
    S_ENV0  = 29'd1 << 10,
    S_ENV1  = 29'd1 << 11,
    S_NORM  = 29'd1 << 12,
    S_LOGI  = 29'd1 << 13,
    S_LOGR  = 29'd1 << 14,
    S_L2    = 29'd1 << 15,
    S_LDB   = 29'd1 << 16,
    S_CURVE = 29'd1 << 17,
    S_KN0   = 29'd1 << 18,
    S_KN1   = 29'd1 << 19,
    S_DIV   = 29'd1 << 20,
    S_LIN   = 29'd1 << 21,
    S_GDB   = 29'd1 << 22,
    S_EXP   = 29'd1 << 23,
    S_GPOW  = 29'd1 << 24,
    S_GMUL  = 29'd1 << 25,
    S_YMUL  = 29'd1 << 26,
    S_SCALE = 29'd1 << 27,
    S_OUT   = 29'd1 << 28
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic signed [15:0] thr_r;
  logic [16:0]        ratio_r;
  logic [13:0]        knee_r;
  logic signed [14:0] makeup_r;
  logic [15:0]        att_r;
  logic [15:0]        rel_r;
  logic [15:0]        msf_r;
  logic               rms_r;

  // Per-channel detector state.
  logic [31:0] hold_mem_r [adrc_pkg::CHANNELS];
  logic [31:0] env_mem_r  [adrc_pkg::CHANNELS];
  logic [47:0] ms_mem_r   [adrc_pkg::CHANNELS];

  // Working registers of the item in hand.
  logic [adrc_pkg::CH_BITS-1:0] ch_r;
  logic                         neg_r;
  logic [SB-1:0]                mag_r;
  logic [31:0]                  hold_w_r;
  logic [31:0]                  env_w_r;
  logic [47:0]                  ms_w_r;
  logic [31:0]                  rect_r;
  logic [46:0]                  sq_r;
  logic [65:0]                  acc_r;
  logic [63:0]                  srem_r;
  logic [63:0]                  sroot_r;
  logic [63:0]                  sbit_r;
  logic [4:0]                   cnt_r;
  logic [31:0]                  m_r;
  logic [4:0]                   pcnt_r;
  logic [15:0]                  frac_r;
  logic signed [19:0]           l_r;
  logic signed [19:0]           delta_r;
  logic [30:0]                  dnum_r;
  logic [13:0]                  drem_r;
  logic [30:0]                  dq_r;
  logic                         dneg_r;
  logic signed [11:0]           ip_r;
  logic [15:0]                  ef_r;
  logic [30:0]                  g_r;
  logic [3:0]                   k_r;
  logic [SB-1:0]                res_r;

  logic                         out_valid_r;
  logic [adrc_pkg::CH_BITS-1:0] out_ch_r;
  logic [SB-1:0]                out_smp_r;

  // Shared multiplier.
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] p_r;

  adrc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  logic                        in_acc;
  logic                        ch_ok;
  logic [adrc_pkg::CH_IDX-1:0] in_idx;
  logic [adrc_pkg::CH_IDX-1:0] ch_idx;
  logic [SB-1:0]               in_mag;
  logic [31:0]                 level;

  assign in_acc = in_valid && in_ready;
  assign ch_ok  = 32'(in_channel) < adrc_pkg::CHANNELS;
  assign in_idx = in_channel[adrc_pkg::CH_IDX-1:0];
  assign ch_idx = ch_r[adrc_pkg::CH_IDX-1:0];
  assign in_mag = in_sample[SB-1] ? SB'(-in_sample) : SB'(in_sample);
  assign level  = 32'(mag_r) << adrc_pkg::LEVEL_SHIFT;

  // Mean-square update and root step.
  logic [16:0] msf_inv, att_inv;
  logic [65:0] ms_sum, env_sum;
  logic [47:0] ms_new;
  logic [31:0] env_new;
  logic [63:0] s_trial;
  logic        s_ge;
  logic [63:0] sroot_nxt;
  logic [31:0] dec;
  logic [31:0] hold_new;

  assign msf_inv   = 17'd65536 - 17'(msf_r);
  assign att_inv   = 17'd65536 - 17'(att_r);
  assign ms_sum    = acc_r + (66'(p_r[63:0]) << 24) + 66'd32768;
  assign ms_new    = ms_sum[63:16];
  assign env_sum   = acc_r + 66'(p_r[63:0]) + 66'd32768;
  assign env_new   = env_sum[47:16];
  assign s_trial   = sroot_r + sbit_r;
  assign s_ge      = srem_r >= s_trial;
  assign sroot_nxt = s_ge ? (sroot_r >> 1) + sbit_r : sroot_r >> 1;
  assign dec       = p_r[47:16];
  assign hold_new  = (rect_r > dec) ? rect_r : dec;

  // Log squaring round.
  logic [31:0] t_sq;
  assign t_sq = p_r[61:30];

  logic signed [5:0]  pm;
  logic signed [21:0] l2;
  assign pm = 6'(pcnt_r) - 6'sd31;
  assign l2 = {pm, frac_r};

  logic signed [PW-1:0] l_rnd;
  assign l_rnd = p_r + PW'(64'd8388608);

  // Static curve.
  logic signed [19:0] over;
  logic signed [19:0] aover;
  logic signed [17:0] rm;
  logic               knee_hit;
  logic signed [20:0] u_full;
  logic [15:0]        u;

  assign over     = l_r - 20'(thr_r);
  assign aover    = over[19] ? -over : over;
  assign rm       = $signed({1'b0, ratio_r}) - 18'sd65536;
  assign knee_hit = (knee_r != 14'd0) && ({1'b0, aover} <<< 1) <= $signed(21'(knee_r));
  assign u_full   = (21'(over) <<< 1) + $signed(21'(knee_r));
  assign u        = u_full[15:0];

  logic signed [PW-1:0] kn_num;
  logic signed [31:0]   kn_n2;
  logic signed [31:0]   kn_abs;
  assign kn_num = p_r + $signed(PW'(knee_r) << 18);
  assign kn_n2  = kn_num[50:19];
  assign kn_abs = -kn_n2 + $signed(32'(knee_r)) - 32'sd1;

  logic [14:0] d_rem2;
  logic        d_ge;
  logic [30:0] dq_nxt;
  assign d_rem2 = {drem_r, dnum_r[30]};
  assign d_ge   = d_rem2 >= 15'(knee_r);
  assign dq_nxt = {dq_r[29:0], d_ge};

  logic signed [PW-1:0] lin_rnd;
  assign lin_rnd = p_r + PW'(64'd32768);

  logic signed [19:0] gdb;
  assign gdb = delta_r + 20'(makeup_r);

  logic signed [PW-1:0] e_rnd;
  logic signed [27:0]   e16;
  assign e_rnd = p_r + PW'(64'd128);
  assign e16   = e_rnd[35:8];

  logic ef_bit;
  assign ef_bit = ef_r[4'd15 - k_r];

  logic [PW-1:0] g_rnd;
  assign g_rnd = p_r + PW'(64'd536870912);

  // Final scaling and saturation.
  logic [63:0]        p64;
  logic [63:0]        lim;
  logic [63:0]        y;
  logic signed [12:0] s;
  logic [12:0]        sh;
  logic [5:0]         sa;
  logic [SB-1:0]      y_out;

  always_comb begin
    p64 = p_r[63:0];
    lim = neg_r ? (64'd1 << (SB - 1)) : ((64'd1 << (SB - 1)) - 64'd1);
    s   = 13'sd30 - 13'(ip_r);
    sh  = 13'(-s);
    sa  = s[5:0];
    if (s > 13'sd63) begin
      y = '0;
    end else if (s > 13'sd0) begin
      y = (p64 + (64'd1 << 6'(sa - 6'd1))) >> sa;
    end else if (p64 == 64'd0) begin
      y = '0;
    end else if (sh >= 13'd32 || p64 > (lim >> sh[4:0])) begin
      y = lim;
    end else begin
      y = p64 << sh[4:0];
    end
    if (y > lim) begin
      y = lim;
    end
    y_out = neg_r ? SB'(-y) : SB'(y);
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQ: begin
        mul_a = MW'(level);
        mul_b = MW'(level);
      end
      S_MS0: begin
        mul_a = MW'(msf_r);
        mul_b = MW'(ms_w_r[23:0]);
      end
      S_MS1: begin
        mul_a = MW'(msf_r);
        mul_b = MW'(ms_w_r[47:24]);
      end
      S_MS2: begin
        mul_a = MW'(msf_inv);
        mul_b = MW'(sq_r[23:0]);
      end
      S_MS3: begin
        mul_a = MW'(msf_inv);
        mul_b = MW'(sq_r[46:24]);
      end
      S_DEC: begin
        mul_a = MW'(rel_r);
        mul_b = MW'(hold_w_r);
      end
      S_HOLD: begin
        mul_a = MW'(att_r);
        mul_b = MW'(env_w_r);
      end
      S_ENV0: begin
        mul_a = MW'(att_inv);
        mul_b = MW'(hold_w_r);
      end
      S_LOGI: begin
        mul_a = MW'(m_r);
        mul_b = MW'(m_r);
      end
      S_L2: begin
        mul_a = MW'(l2);
        mul_b = MW'(adrc_pkg::DB_PER_OCTAVE);
      end
      S_CURVE: begin
        if (knee_hit) begin
          mul_a = MW'(u);
          mul_b = MW'(u);
        end else begin
          mul_a = MW'(over);
          mul_b = MW'(rm);
        end
      end
      S_KN0: begin
        mul_a = MW'(rm);
        mul_b = $signed(p_r[MW-1:0]);
      end
      S_GDB: begin
        mul_a = MW'(gdb);
        mul_b = MW'(adrc_pkg::OCTAVE_PER_DB20);
      end
      S_GPOW: begin
        mul_a = MW'(g_r);
        mul_b = MW'(adrc_pkg::ROOT_TAB[k_r]);
      end
      S_YMUL: begin
        mul_a = MW'(mag_r);
        mul_b = MW'(g_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!ch_ok) begin
            state_nxt = S_OUT;
          end else if (rms_r) begin
            state_nxt = S_SQ;
          end else begin
            state_nxt = S_DEC;
          end
        end
      end
      S_SQ:   state_nxt = S_MS0;
      S_MS0:  state_nxt = S_MS1;
      S_MS1:  state_nxt = S_MS2;
      S_MS2:  state_nxt = S_MS3;
      S_MS3:  state_nxt = S_MS4;
      S_MS4:  state_nxt = S_SQRT;
      S_SQRT: state_nxt = (cnt_r == 5'd31) ? S_DEC : S_SQRT;
      S_DEC:  state_nxt = S_HOLD;
      S_HOLD: state_nxt = S_ENV0;
      S_ENV0: state_nxt = S_ENV1;
      S_ENV1: state_nxt = (env_new == 32'd0) ? S_CURVE : S_NORM;
      S_NORM: state_nxt = m_r[31] ? S_LOGI : S_NORM;
      S_LOGI: state_nxt = S_LOGR;
      S_LOGR: state_nxt = (cnt_r == 5'd15) ? S_L2 : S_LOGI;
      S_L2:   state_nxt = S_LDB;
      S_LDB:  state_nxt = S_CURVE;
      S_CURVE: begin
        if (knee_hit) begin
          state_nxt = S_KN0;
        end else if (over > 20'sd0) begin
          state_nxt = S_LIN;
        end else begin
          state_nxt = S_GDB;
        end
      end
      S_KN0:  state_nxt = S_KN1;
      S_KN1:  state_nxt = S_DIV;
      S_DIV:  state_nxt = (cnt_r == 5'd30) ? S_GDB : S_DIV;
      S_LIN:  state_nxt = S_GDB;
      S_GDB:  state_nxt = S_EXP;
      S_EXP:  state_nxt = S_GPOW;
      S_GPOW: begin
        if (ef_bit) begin
          state_nxt = S_GMUL;
        end else if (k_r == 4'd15) begin
          state_nxt = S_YMUL;
        end
      end
      S_GMUL:  state_nxt = (k_r == 4'd15) ? S_YMUL : S_GPOW;
      S_YMUL:  state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_OUT;
      S_OUT:   state_nxt = (!out_valid_r || out_ready) ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= adrc_pkg::THRESHOLD_RST;
      ratio_r  <= adrc_pkg::RATIO_RST;
      knee_r   <= adrc_pkg::KNEE_RST;
      makeup_r <= adrc_pkg::MAKEUP_RST;
      att_r    <= adrc_pkg::ATTACK_RST;
      rel_r    <= adrc_pkg::RELEASE_RST;
      msf_r    <= adrc_pkg::MSQ_RST;
      rms_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (adrc_pkg::cfg_reg_t'(cfg_index))
        adrc_pkg::REG_THRESHOLD: thr_r    <= cfg_data[15:0];
        adrc_pkg::REG_RATIO_INV: ratio_r  <= cfg_data[16:0];
        adrc_pkg::REG_KNEE:      knee_r   <= cfg_data[13:0];
        adrc_pkg::REG_MAKEUP:    makeup_r <= cfg_data[14:0];
        adrc_pkg::REG_ATTACK:    att_r    <= cfg_data[15:0];
        adrc_pkg::REG_RELEASE:   rel_r    <= cfg_data[15:0];
        adrc_pkg::REG_MSQ:       msf_r    <= cfg_data[15:0];
        adrc_pkg::REG_RMS_MODE:  rms_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Detector state per channel, written once the new envelope is known.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < adrc_pkg::CHANNELS; c++) begin
        hold_mem_r[c] <= '0;
        env_mem_r[c]  <= '0;
        ms_mem_r[c]   <= '0;
      end
    end else if (state_r == S_ENV1) begin
      hold_mem_r[ch_idx] <= hold_w_r;
      env_mem_r[ch_idx]  <= env_new;
      ms_mem_r[ch_idx]   <= ms_w_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ch_r     <= in_channel;
          neg_r    <= in_sample[SB-1];
          mag_r    <= in_mag;
          res_r    <= in_sample;
          hold_w_r <= hold_mem_r[in_idx];
          env_w_r  <= env_mem_r[in_idx];
          ms_w_r   <= ms_mem_r[in_idx];
          rect_r   <= 32'(in_mag) << adrc_pkg::LEVEL_SHIFT;
        end
      end
      S_MS0: sq_r  <= p_r[62:16];
      S_MS1: acc_r <= 66'(p_r[63:0]);
      S_MS2: acc_r <= acc_r + (66'(p_r[63:0]) << 24);
      S_MS3: acc_r <= acc_r + 66'(p_r[63:0]);
      S_MS4: begin
        ms_w_r  <= ms_new;
        srem_r  <= 64'(ms_new) << 16;
        sroot_r <= '0;
        sbit_r  <= 64'h4000_0000_0000_0000;
        cnt_r   <= '0;
      end
      S_SQRT: begin
        if (s_ge) begin
          srem_r <= srem_r - s_trial;
        end
        sroot_r <= sroot_nxt;
        sbit_r  <= sbit_r >> 2;
        cnt_r   <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          rect_r <= sroot_nxt[31:0];
        end
      end
      S_HOLD: hold_w_r <= hold_new;
      S_ENV0: acc_r    <= 66'(p_r[63:0]);
      S_ENV1: begin
        env_w_r <= env_new;
        m_r     <= env_new;
        pcnt_r  <= 5'd31;
        l_r     <= adrc_pkg::DB_FLOOR_Q8;
      end
      S_NORM: begin
        // Bring the leading one to bit 31, then take it as Q1.30.
        if (m_r[31]) begin
          m_r    <= m_r >> 1;
          cnt_r  <= '0;
          frac_r <= '0;
        end else begin
          m_r    <= m_r << 1;
          pcnt_r <= pcnt_r - 5'd1;
        end
      end
      S_LOGR: begin
        frac_r <= {frac_r[14:0], t_sq[31]};
        m_r    <= t_sq[31] ? t_sq >> 1 : t_sq;
        cnt_r  <= cnt_r + 5'd1;
      end
      S_LDB: l_r <= l_rnd[43:24];
      S_CURVE: delta_r <= '0;
      S_KN1: begin
        // Floor division by the knee width works on the magnitude.
        dneg_r <= kn_n2[31];
        dnum_r <= kn_n2[31] ? kn_abs[30:0] : kn_n2[30:0];
        drem_r <= '0;
        dq_r   <= '0;
        cnt_r  <= '0;
      end
      S_DIV: begin
        drem_r <= d_ge ? 14'(d_rem2 - 15'(knee_r)) : d_rem2[13:0];
        dnum_r <= dnum_r << 1;
        dq_r   <= dq_nxt;
        cnt_r  <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          delta_r <= dneg_r ? -$signed(dq_nxt[19:0]) : $signed(dq_nxt[19:0]);
        end
      end
      S_LIN: delta_r <= lin_rnd[35:16];
      S_EXP: begin
        ip_r <= e16[27:16];
        ef_r <= e16[15:0];
        g_r  <= 31'd1 << 30;
        k_r  <= '0;
      end
      S_GPOW: begin
        if (!ef_bit && k_r != 4'd15) begin
          k_r <= k_r + 4'd1;
        end
      end
      S_GMUL: begin
        g_r <= g_rnd[60:30];
        if (k_r != 4'd15) begin
          k_r <= k_r + 4'd1;
        end
      end
      S_SCALE: res_r <= y_out;
      default: ;
    endcase
  end

  // Output register: it holds a finished item while the next one is in work.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_ch_r  <= ch_r;
      out_smp_r <= res_r;
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_channel_out = out_ch_r;
  assign out_sample_out  = out_smp_r;

endmodule

// ===== design/adrc_chk.sv =====
`include "assert_macros.svh"

module adrc_chk (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic [adrc_pkg::CH_BITS-1:0]            in_channel,
  input logic signed [adrc_pkg::SAMPLE_BITS-1:0] in_sample,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic [adrc_pkg::CH_BITS-1:0]            out_channel_out,
  input logic signed [adrc_pkg::SAMPLE_BITS-1:0] out_sample_out,
  input logic                                    cfg_valid,
  input logic                                    cfg_ready,
  input logic [adrc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input logic [adrc_pkg::CFG_DATA_W-1:0]         cfg_data
);

  // A stalled result keeps its item.
  `ADRC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_sample_out) && $stable(out_channel_out))

  // Only one item is in work at a time.
  `ADRC_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // Handing a result to the output register frees the input side.
  `ADRC_ASSERT(a_result_frees_input, clk, rst_n, $rose(out_valid) |-> in_ready)

  // Reset leaves the block idle with no result pending.
  `ADRC_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready)

endmodule

bind audio_dynamic_range_compressor adrc_chk u_adrc_chk (.*);

// ===== dv/audio_dynamic_range_compressor_tb.sv =====
module audio_dynamic_range_compressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import adrc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 250;

  typedef struct {
    bit [2:0]  channel;
    bit [23:0] sample;
  } gain_result_t;

  class adrc_scoreboard;
    longint    threshold;
    bit [63:0] ratio_inv, knee, attack, release_f, msq_f;
    longint    makeup;
    bit        rms_mode;
    bit [31:0] hold_lvl [8];
    bit [31:0] env_lvl  [8];
    bit [63:0] msq_lvl  [8];
    bit [63:0] roots    [16];
    gain_result_t expected_q [$];
    int mismatches;
    int items_seen;
    int results_seen;

    function new();
      threshold = -5120;
      ratio_inv = 16384;
      knee      = 0;
      makeup    = 0;
      attack    = 64880;
      release_f = 65208;
      msq_f     = 65208;
      rms_mode  = 0;
      foreach (hold_lvl[c]) begin
        hold_lvl[c] = 0;
        env_lvl[c]  = 0;
        msq_lvl[c]  = 0;
      end
      roots[0] = int_sqrt(64'd1 << 61);
      for (int k = 1; k < 16; k++) roots[k] = int_sqrt(roots[k-1] << 30);
    endfunction

    // Builds the root one bit at a time from the top.
    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint round_div(longint n, longint d);
      return floor_div(2 * n + d, 2 * d);
    endfunction

    function longint level_in_db(bit [31:0] env);
      int        msb;
      bit [63:0] m, frac;
      longint    l2;
      if (env == 0) return -61440;
      msb = 0;
      frac = 0;
      for (int i = 0; i < 32; i++) if (env[i]) msb = i;
      m = ({32'd0, env} << 30) >> msb;
      for (int i = 0; i < 16; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd1 << 31)) begin
          frac[0] = 1'b1;
          m = m >> 1;
        end
      end
      l2 = (longint'(msb) - 31) * 65536 + longint'(frac);
      return round_div(l2 * 394566, longint'(1) << 24);
    endfunction

    function void write_reg(cfg_reg_t idx, bit [31:0] v);
      case (idx)
        REG_THRESHOLD: threshold = longint'($signed(v[15:0]));
        REG_RATIO_INV: ratio_inv = v[16:0];
        REG_KNEE:      knee      = v[13:0];
        REG_MAKEUP:    makeup    = longint'($signed(v[14:0]));
        REG_ATTACK:    attack    = v[15:0];
        REG_RELEASE:   release_f = v[15:0];
        REG_MSQ:       msq_f     = v[15:0];
        REG_RMS_MODE:  rms_mode  = v[0];
        default: ;
      endcase
    endfunction

    function gain_result_t compress(bit [2:0] ch, bit [23:0] x);
      gain_result_t res;
      longint    xs, lvl_db, over, aover, rm, u, delta, gdb, e16, ip, s;
      bit        neg;
      bit [63:0] mag, level, sq, rect, dec, hold, env, g, p, y, lim, frac;
      xs  = longint'($signed(x));
      neg = xs < 0;
      mag = neg ? -xs : xs;
      level = mag << 8;
      if (rms_mode) begin
        sq = (level * level) >> 16;
        msq_lvl[ch] = (msq_f * msq_lvl[ch] + (65536 - msq_f) * sq + 32768) >> 16;
        rect = int_sqrt(msq_lvl[ch] << 16);
      end else begin
        rect = level;
      end
      dec  = (release_f * hold_lvl[ch]) >> 16;
      hold = (rect > dec) ? rect : dec;
      hold_lvl[ch] = hold[31:0];
      env = (attack * env_lvl[ch] + (65536 - attack) * hold + 32768) >> 16;
      env_lvl[ch] = env[31:0];

      lvl_db = level_in_db(env[31:0]);
      over  = lvl_db - threshold;
      aover = (over < 0) ? -over : over;
      rm    = longint'(ratio_inv) - 65536;
      if (knee > 0 && 2 * aover <= longint'(knee)) begin
        u = 2 * over + longint'(knee);
        delta = round_div(rm * u * u, 8 * longint'(knee) * 65536);
      end else if (over > 0) begin
        delta = round_div(over * rm, 65536);
      end else begin
        delta = 0;
      end
      gdb = delta + makeup;

      e16  = round_div(gdb * 10885, 256);
      ip   = floor_div(e16, 65536);
      frac = e16 - ip * 65536;
      g = 64'd1 << 30;
      for (int k = 0; k < 16; k++)
        if (frac[15-k]) g = (g * roots[k] + (64'd1 << 29)) >> 30;

      lim = neg ? (64'd1 << 23) : ((64'd1 << 23) - 1);
      p = mag * g;
      s = 30 - ip;
      if (s > 63) y = 0;
      else if (s > 0) y = (p + (64'd1 << (s - 1))) >> s;
      else if (p == 0) y = 0;
      else if (-s >= 32 || p > (lim >> (-s))) y = lim;
      else y = p << (-s);
      if (y > lim) y = lim;
      res.channel = ch;
      res.sample  = neg ? 24'(-y) : 24'(y);
      return res;
    endfunction

    function void note_input(bit [2:0] ch, bit [23:0] x);
      expected_q.push_back(compress(ch, x));
      items_seen++;
    endfunction

    task report(string what, bit [31:0] got, bit [31:0] want);
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(bit [2:0] ch, bit [23:0] y);
      gain_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with nothing outstanding, sample", y, 0);
      end else begin
        want = expected_q.pop_front();
        if (ch != want.channel) report("channel", ch, want.channel);
        if (y != want.sample) report("sample", y, want.sample);
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [CH_BITS-1:0]            in_channel;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic [CH_BITS-1:0]            out_channel_out;
  logic signed [SAMPLE_BITS-1:0] out_sample_out;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_data;

  adrc_scoreboard gain_sb = new();
  logic hold_trig;
  logic hold_seen;
  int   hold_left;
  int   ready_pct;
  int   idle_cycles;

  audio_dynamic_range_compressor i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_channel      (in_channel),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_channel_out (out_channel_out),
    .out_sample_out  (out_sample_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #4 clk = ~clk;

  // Result side: random back-pressure in stretches, plus a long hold-off on request.
  always @(posedge clk) begin
    if (out_valid && out_ready) gain_sb.check_result(out_channel_out, out_sample_out);
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= hold_trig;
      hold_left <= 0;
      ready_pct <= 100;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 299) == 0) begin
      hold_left <= $urandom_range(30, 80);
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 30 : 100;
      out_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(bit [2:0] ch, bit [23:0] x, int gap);
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_sample  <= x;
    do @(posedge clk); while (!in_ready);
    gain_sb.note_input(ch, x);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Stop offering items until every outstanding result is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (gain_sb.expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_reg(cfg_reg_t idx, bit [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    gain_sb.write_reg(idx, v);
  endtask

  task automatic program_all(bit [31:0] thr, bit [31:0] ratio, bit [31:0] kn,
                             bit [31:0] mk, bit [31:0] att, bit [31:0] rel,
                             bit [31:0] msq, bit [31:0] rms);
    set_reg(REG_THRESHOLD, thr);
    set_reg(REG_RATIO_INV, ratio);
    set_reg(REG_KNEE, kn);
    set_reg(REG_MAKEUP, mk);
    set_reg(REG_ATTACK, att);
    set_reg(REG_RELEASE, rel);
    set_reg(REG_MSQ, msq);
    set_reg(REG_RMS_MODE, rms);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [23:0] random_sample();
    case ($urandom_range(0, 5))
      0:       return 24'($signed($urandom_range(0, 511)) - 256);
      1:       return ($urandom_range(0, 1) != 0) ? 24'h7fffff : 24'h800000;
      2:       return 24'($urandom) >>> $urandom_range(0, 20);
      default: return 24'($urandom);
    endcase
  endfunction

  // Bursts on one channel build up the envelope so that the curve is exercised.
  task automatic random_phase(int n, bit squeeze);
    bit [2:0] ch;
    int burst;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == n / 3) hold_trig <= ~hold_trig;
      if (burst == 0) begin
        ch = $urandom_range(0, 7);
        burst = $urandom_range(1, 12);
      end
      burst--;
      send_item(ch, random_sample(), squeeze ? 0 : random_gap());
    end
  endtask

  initial begin
    bit [23:0] edge_samples [8];
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_channel <= '0;
    in_sample  <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_THRESHOLD;
    cfg_data   <= '0;
    hold_trig  <= 1'b0;
    edge_samples = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff,
                     24'h000001, 24'h400000, 24'hc00000, 24'h555555};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a silent channel first, so the level sits on the dB floor.
    for (int c = 0; c < 8; c++) send_item(c, edge_samples[c], random_gap());
    for (int i = 0; i < 8; i++) send_item(1, 24'h7fffff, 0);
    drain();

    // Soft knee, RMS, widest makeup and instant smoothing.
    program_all(-24576, 0, 12288, 12288, 0, 0, 0, 1);
    for (int c = 0; c < 8; c++) send_item(c, edge_samples[7-c], random_gap());
    random_phase(150, 1'b0);
    drain();

    program_all(0, 65536, 0, -12288, 65535, 65535, 65535, 0);
    random_phase(150, 1'b0);
    drain();

    // Expansion with positive makeup drives the gain into saturation.
    program_all(-2000, 131071, 0, 12288, 0, 30000, 20000, 1);
    random_phase(120, 1'b0);
    drain();

    // Strongest compression with the lowest makeup makes the gain vanish.
    program_all(-24576, 0, 0, -12288, 1000, 65535, 40000, 0);
    random_phase(120, 1'b1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      program_all($urandom_range(0, 24576) * -1, $urandom_range(0, 65536),
                  ($urandom_range(0, 1) != 0) ? $urandom_range(1, 12288) : 0,
                  $urandom_range(0, 24576) - 12288, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 1));
      random_phase(120, ph == 2);
      drain();
    end

    // Register values past their stated ranges are used as written.
    program_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom);
    random_phase(100, 1'b0);
    drain();

    $display("Covered %0d items and %0d results over eleven register settings,",
             gain_sb.items_seen, gain_sb.results_seen);
    $display("peak and RMS detection, hard and soft knee, saturation and stalls.");
    if (gain_sb.mismatches == 0 && gain_sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
